>>> sv/ilt_pkg.sv
package ilt_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 16;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int OP_W        = 2;
	localparam int POS_W       = 7;
	localparam int STATUS_W    = 2;
	localparam int LEN_W       = 7;

	localparam logic [OP_W-1:0] OP_READ   = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd2;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic             ins_en;
		logic             del_en;
		logic [POS_W-1:0] pos;
		value_t           value;
	} cell_ctl_t;

endpackage

>>> sv/ilt_if.sv
interface ilt_req_if;
	logic                             valid;
	logic                             ready;
	logic [ilt_pkg::OP_W-1:0]         op;
	logic [ilt_pkg::POS_W-1:0]        position;
	logic [ilt_pkg::VALUE_WIDTH-1:0]  value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);
endinterface

interface ilt_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [ilt_pkg::VALUE_WIDTH-1:0]  read_value;
	logic [ilt_pkg::STATUS_W-1:0]     status;
	logic [ilt_pkg::LEN_W-1:0]        length;

	modport source (output valid, output read_value, output status, output length, input ready);
	modport sink (input valid, input read_value, input status, input length, output ready);
endinterface

>>> sv/ilt_cell.sv
module ilt_cell (
	input  logic                          clk,
	input  logic [ilt_pkg::IDX_W-1:0]     idx,
	input  ilt_pkg::cell_ctl_t            ctl,
	input  ilt_pkg::value_t               left,
	input  ilt_pkg::value_t               right,
	output ilt_pkg::value_t               data
);
	import ilt_pkg::*;

	logic [POS_W-1:0] idx_x;
	value_t           data_q;

	assign idx_x = POS_W'(idx);
	assign data  = data_q;

	// Insert moves the tail one cell up; delete pulls it one cell down.
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (idx_x > ctl.pos) begin
				data_q <= left;
			end else if (idx_x == ctl.pos) begin
				data_q <= ctl.value;
			end
		end else if (ctl.del_en && idx_x >= ctl.pos) begin
			data_q <= right;
		end
	end

endmodule

>>> sv/ilt_ctrl.sv
module ilt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	ilt_req_if.sink              req,
	ilt_rsp_if.source            rsp,
	input  ilt_pkg::value_t      rd_data,
	output ilt_pkg::cell_ctl_t   cell_ctl,
	output logic [ilt_pkg::CNT_W-1:0] count
);
	import ilt_pkg::*;

	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_d;
	logic                out_valid_q;
	value_t              rd_value_q;
	logic [STATUS_W-1:0] status_q;
	logic [LEN_W-1:0]    length_q;
	logic                accept;
	logic                ins;
	logic                del;
	logic [POS_W-1:0]    ins_pos;
	logic [CNT_W-1:0]    pos_x;
	value_t              rd;
	logic [STATUS_W-1:0] st;

	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign pos_x     = CNT_W'(req.position);

	always_comb begin
		ins     = 1'b0;
		del     = 1'b0;
		ins_pos = req.position;
		rd      = '0;
		st      = ST_DONE;
		unique case (req.op)
			OP_READ: begin
				if (pos_x < cnt_q) begin
					rd = rd_data;
				end else begin
					st = ST_BAD_POS;
				end
			end
			OP_INSERT: begin
				if (pos_x > cnt_q) begin
					st = ST_BAD_POS;
				end else if (cnt_q == CNT_W'(CAPACITY)) begin
					st = ST_FULL;
				end else begin
					ins = 1'b1;
				end
			end
			OP_APPEND: begin
				ins_pos = POS_W'(cnt_q);
				if (cnt_q == CNT_W'(CAPACITY)) begin
					st = ST_FULL;
				end else begin
					ins = 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos_x < cnt_q) begin
					del = 1'b1;
				end else begin
					st = ST_BAD_POS;
				end
			end
			default: begin
				st = ST_BAD_POS;
			end
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (ins) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (del) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	assign cell_ctl.ins_en = accept && ins;
	assign cell_ctl.del_en = accept && del;
	assign cell_ctl.pos    = ins_pos;
	assign cell_ctl.value  = req.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_value_q <= rd;
			status_q   <= st;
			length_q   <= LEN_W'(cnt_d);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = rd_value_q;
	assign rsp.status     = status_q;
	assign rsp.length     = length_q;
	assign count          = cnt_q;

endmodule

>>> sv/indexed_list_table_top.sv
// Ordered list of up to CAPACITY 16-bit values held in a chain of cells.
// Requests arrive on req (op, position, value) and each one yields exactly
// one result on rsp (read_value, status, length). A transfer happens when
// valid and ready are both high at a rising clock edge.
// Every cell shifts, loads or holds in the same cycle, so an insert or a
// delete at any position takes effect at the edge that accepts it. The
// result is registered and is valid in the cycle after the request is taken;
// one request is taken per cycle, limited only by the single output register.
// A read selects the addressed cell directly; read_value is zero for every
// other operation and for a failed read.
// When the receiver stalls, the output register holds its result and req
// ready drops until that result has been taken; the list is not changed
// meanwhile.
// Reset (arst_n low) empties the list at once; cell contents are not
// cleared, since positions at or past the length are never read.
module indexed_list_table_top (
	input  logic       clk,
	input  logic       arst_n,
	ilt_req_if.sink    req,
	ilt_rsp_if.source  rsp
);
	import ilt_pkg::*;

	cell_ctl_t        cell_ctl;
	value_t           cell_data [CAPACITY];
	value_t           rd_data;
	logic [CNT_W-1:0] count;

	assign rd_data = cell_data[req.position[IDX_W-1:0]];

	ilt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rd_data  (rd_data),
		.cell_ctl (cell_ctl),
		.count    (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t left;
		value_t right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_left
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_right
			assign right = cell_data[i+1];
		end
		ilt_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(i)),
			.ctl   (cell_ctl),
			.left  (left),
			.right (right),
			.data  (cell_data[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(CAPACITY))
		else $error("list count exceeds capacity");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.length == LEN_W'(CAPACITY)))
		else $error("full status with list not at capacity");

	a_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("accepted request produced no result");

	a_no_change_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.op != OP_READ)
		|=> (rsp.status == ST_DONE || count == $past(count)))
		else $error("failed operation changed the list length");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import ilt_pkg::*;

	typedef struct {
		logic [OP_W-1:0]     req_op;
		logic [POS_W-1:0]    req_pos;
		value_t              read_value;
		logic [STATUS_W-1:0] status;
		logic [LEN_W-1:0]    length;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ilt_req_if req_if ();
	ilt_rsp_if rsp_if ();

	indexed_list_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	// Shadow copy of the list, updated when a request transfer happens.
	value_t       list_mem [CAPACITY];
	int unsigned  list_len;
	list_result_t expected_results [$];
	list_result_t oldest_result;

	int  fault_count;
	int  checked_count;
	int  peak_len;
	int  op_seen [4];
	int  status_seen [4];
	int  req_gap_pct;
	int  rsp_stall_pct;
	int  hold_req;
	int  stall_left;
	bit  grow_mode;

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void record_fault(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void apply_list_op(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input value_t val);
		list_result_t r;
		int unsigned  at;
		r.req_op = op;
		r.req_pos = pos;
		r.read_value = '0;
		r.status = ST_DONE;
		at = (op == OP_APPEND) ? list_len : pos;
		case (op)
			OP_READ: begin
				if (pos < list_len)
					r.read_value = list_mem[pos];
				else
					r.status = ST_BAD_POS;
			end
			OP_INSERT, OP_APPEND: begin
				// The position check takes precedence over the full check.
				if (at > list_len) begin
					r.status = ST_BAD_POS;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (int i = list_len; i > at; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[at] = val;
					list_len++;
				end
			end
			default: begin
				if (pos < list_len) begin
					for (int i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end else begin
					r.status = ST_BAD_POS;
				end
			end
		endcase
		r.length = LEN_W'(list_len);
		if (list_len > peak_len)
			peak_len = list_len;
		op_seen[op]++;
		status_seen[r.status]++;
		expected_results.push_back(r);
	endfunction

	task automatic send_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input value_t val);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < req_gap_pct)
			gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.position <= pos;
		req_if.value <= val;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		apply_list_op(op, pos, val);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic value_t pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return value_t'($urandom);
		endcase
	endfunction

	// Mostly positions that hit the list, with some anywhere in the field (always for appends).
	function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
		if (op == OP_APPEND || $urandom_range(0, 99) < 12)
			return POS_W'($urandom_range(0, 127));
		if (op == OP_INSERT)
			return POS_W'($urandom_range(0, list_len));
		if (list_len == 0)
			return '0;
		return POS_W'($urandom_range(0, list_len - 1));
	endfunction

	// The length wanders between empty and full: growth and shrink phases
	// alternate, and each lingers at its end for a few requests.
	task automatic send_random_req();
		logic [OP_W-1:0] op;
		int              roll;
		if (grow_mode && list_len >= CAPACITY && $urandom_range(0, 5) == 0)
			grow_mode = 1'b0;
		else if (!grow_mode && list_len == 0 && $urandom_range(0, 5) == 0)
			grow_mode = 1'b1;
		else if ($urandom_range(0, 99) == 0)
			grow_mode = !grow_mode;
		roll = $urandom_range(0, 99);
		if (grow_mode)
			op = roll < 25 ? OP_READ : roll < 60 ? OP_INSERT : roll < 85 ? OP_APPEND : OP_DELETE;
		else
			op = roll < 30 ? OP_READ : roll < 40 ? OP_INSERT : roll < 50 ? OP_APPEND : OP_DELETE;
		send_req(op, pick_position(op), pick_value());
	endtask

	task automatic test_directed();
		req_gap_pct = 20;
		rsp_stall_pct = 20;
		send_req(OP_READ, 0, 16'h1111);
		send_req(OP_DELETE, 0, 16'h2222);
		send_req(OP_INSERT, 1, 16'h3333);
		send_req(OP_DELETE, 127, 16'hffff);
		send_req(OP_INSERT, 0, 16'hffff);
		send_req(OP_APPEND, 127, 16'h0000);
		send_req(OP_INSERT, 2, 16'h8001);
		send_req(OP_INSERT, 1, 16'h7ffe);
		send_req(OP_READ, 0, 16'h0000);
		send_req(OP_READ, 3, 16'h0000);
		send_req(OP_READ, 1, 16'h0000);
		send_req(OP_READ, 4, 16'h0000);
		send_req(OP_READ, 127, 16'h0000);
		send_req(OP_INSERT, 5, 16'h4444);
		send_req(OP_INSERT, 127, 16'h5555);
		send_req(OP_DELETE, 1, 16'h0000);
		send_req(OP_READ, 1, 16'hffff);
		send_req(OP_DELETE, 2, 16'h0000);
		send_req(OP_DELETE, 2, 16'h0000);
		send_req(OP_DELETE, 0, 16'h0000);
		send_req(OP_READ, 0, 16'h0000);
		send_req(OP_DELETE, 0, 16'h0000);
		send_req(OP_APPEND, 0, 16'h5555);
		send_req(OP_INSERT, 0, 16'haaaa);
		send_req(OP_READ, 0, 16'h0000);
		wait_for_results();
	endtask

	task automatic test_random_mix();
		req_gap_pct = 30;
		rsp_stall_pct = 30;
		grow_mode = 1'b1;
		repeat (1200)
			send_random_req();
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		req_gap_pct = 0;
		rsp_stall_pct = 0;
		repeat (300)
			send_random_req();
		wait_for_results();
	endtask

	// The receiver holds off while requests keep coming, so the block must
	// stall its input without losing or reordering anything.
	task automatic test_output_stall();
		req_gap_pct = 0;
		rsp_stall_pct = 10;
		hold_req = 120;
		repeat (40)
			send_random_req();
		wait_for_results();
	endtask

	task automatic test_full_list();
		req_gap_pct = 15;
		rsp_stall_pct = 15;
		while (list_len < CAPACITY) begin
			if ($urandom_range(0, 1))
				send_req(OP_APPEND, POS_W'($urandom_range(0, 127)), pick_value());
			else
				send_req(OP_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
		end
		send_req(OP_APPEND, 0, 16'h1234);
		send_req(OP_INSERT, 0, 16'h1234);
		send_req(OP_INSERT, POS_W'(CAPACITY), 16'h1234);
		send_req(OP_INSERT, POS_W'(CAPACITY + 1), 16'h1234);
		send_req(OP_INSERT, 127, 16'h1234);
		send_req(OP_READ, POS_W'(CAPACITY - 1), 16'h0000);
		send_req(OP_READ, POS_W'(CAPACITY), 16'h0000);
		send_req(OP_DELETE, POS_W'(CAPACITY - 1), 16'h0000);
		send_req(OP_INSERT, POS_W'(CAPACITY - 1), 16'hffff);
		send_req(OP_READ, POS_W'(CAPACITY - 1), 16'h0000);
		grow_mode = 1'b1;
		repeat (150)
			send_random_req();
		while (list_len > 0)
			send_req(OP_DELETE, POS_W'($urandom_range(0, list_len - 1)), pick_value());
		grow_mode = 1'b0;
		repeat (60)
			send_random_req();
		wait_for_results();
	endtask

	always @(negedge clk) begin
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end else if (stall_left == 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
			stall_left = pick_gap();
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				record_fault($sformatf("result with nothing pending: value %h status %0d length %0d",
					rsp_if.read_value, rsp_if.status, rsp_if.length));
			end else begin
				oldest_result = expected_results.pop_front();
				checked_count++;
				if (rsp_if.read_value !== oldest_result.read_value)
					record_fault($sformatf("op %0d pos %0d: read_value expected %h, got %h",
						oldest_result.req_op, oldest_result.req_pos,
						oldest_result.read_value, rsp_if.read_value));
				if (rsp_if.status !== oldest_result.status)
					record_fault($sformatf("op %0d pos %0d: status expected %0d, got %0d",
						oldest_result.req_op, oldest_result.req_pos,
						oldest_result.status, rsp_if.status));
				if (rsp_if.length !== oldest_result.length)
					record_fault($sformatf("op %0d pos %0d: length expected %0d, got %0d",
						oldest_result.req_op, oldest_result.req_pos,
						oldest_result.length, rsp_if.length));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.op = OP_READ;
		req_if.position = '0;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		list_len = 0;
		hold_req = 0;
		stall_left = 0;
		rsp_stall_pct = 0;
		req_gap_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_mix();
		test_back_to_back();
		test_output_stall();
		test_full_list();
		wait_for_results();
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0)
			record_fault($sformatf("%0d results never arrived", expected_results.size()));

		$display("run covered %0d reads, %0d inserts, %0d appends, %0d deletes; peak length %0d",
			op_seen[OP_READ], op_seen[OP_INSERT], op_seen[OP_APPEND], op_seen[OP_DELETE],
			peak_len);
		$display("%0d results checked: %0d done, %0d bad position, %0d full; %0d faults",
			checked_count, status_seen[ST_DONE], status_seen[ST_BAD_POS],
			status_seen[ST_FULL], fault_count);
		if (fault_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

>>> sim.f
sv/ilt_pkg.sv
sv/ilt_if.sv
sv/ilt_cell.sv
sv/ilt_ctrl.sv
sv/indexed_list_table_top.sv
verif/tb_top.sv
